// File: design/sklq_pkg.sv
// sklq_pkg: shared types, codes and sizing for the sorted key list queue
// used by sklq_cell and sorted_key_list_queue; no dependencies
package sklq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ACTION_W = 3;
    localparam int ITEM_W   = 32;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam int IN_DATA_W  = ((ACTION_W + ITEM_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((STATUS_W + ITEM_W + KEY_W + OCC_W + 7) / 8) * 8;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_PREPEND    = 3'd0,
        ACT_APPEND     = 3'd1,
        ACT_SORTED_INS = 3'd2,
        ACT_REMOVE_HD  = 3'd3,
        ACT_REMOVE_KEY = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS_ALL,
        CELL_INS_FREE,
        CELL_INS_SORT,
        CELL_DEL_HEAD,
        CELL_DEL_KEY
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic signed [KEY_W-1:0] key;
        logic [ITEM_W-1:0]       item;
    } cell_ctrl_t;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [ITEM_W-1:0]       item;
    } entry_t;

endpackage

// File: design/sorted_key_list_queue.sv
// sorted_key_list_queue: key-ordered list of up to CAPACITY entries built as a row of cells
// depends on sklq_pkg and sklq_cell
// result: the result of a transaction is registered and presented in the cycle after it is accepted
// throughput: one transaction per cycle while the output side keeps taking results; every cell
// updates in the accepting cycle, with the position search rippling along the cell chain
// reset: all cells empty and count zero, no result pending; entry payloads are not cleared
module sorted_key_list_queue
    import sklq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // action[2:0], item_tag[34:3], sort_key[66:35], zero pad
    // master side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], item_out[33:2], key_out[65:34],
                                             // occupancy[70:66], zero pad
);

    // input fields
    logic [ACTION_W-1:0]     in_action;
    logic [ITEM_W-1:0]       in_item;
    logic signed [KEY_W-1:0] in_key;
    logic                    accept;

    // cell chain
    cell_ctrl_t            ctrl;
    entry_t                cell_entry [CAPACITY];
    entry_t                left_entry [CAPACITY];
    entry_t                right_entry [CAPACITY];
    logic [CAPACITY:0]     hit_chain;
    logic [CAPACITY-1:0]   first_vec;
    logic [CAPACITY-1:0]   valid_vec;

    // list state
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  full;
    logic                  empty;

    // derived keys and removed entry
    logic signed [KEY_W-1:0] head_key;
    logic signed [KEY_W-1:0] tail_key;
    logic signed [KEY_W-1:0] ins_key;
    logic signed [KEY_W-1:0] rem_key;
    logic [ITEM_W-1:0]       rem_item;

    // result
    status_t                 status;
    logic [ITEM_W-1:0]       item_out;
    logic signed [KEY_W-1:0] key_out;

    logic                    m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]   m_data_reg, m_data_next;

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_item   = s_tdata[ACTION_W +: ITEM_W];
    assign in_key    = $signed(s_tdata[ACTION_W+ITEM_W +: KEY_W]);

    // a new transaction is taken whenever the output register is free or being emptied
    assign s_tready = ~m_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // head and tail keys for prepend and append
    assign head_key = cell_entry[0].key;

    always_comb
    begin
        tail_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_entry[i].valid && ((i == CAPACITY - 1) || !valid_vec[(i + 1) % CAPACITY]))
                tail_key = tail_key | cell_entry[i].key;
        end
    end

    // key given to a new entry, saturating at the key limits
    always_comb
    begin
        case (in_action)
            ACT_PREPEND:
            begin
                if (empty)
                    ins_key = '0;
                else if (head_key == KEY_MIN)
                    ins_key = KEY_MIN;
                else
                    ins_key = head_key - KEY_W'(1);
            end
            ACT_APPEND:
            begin
                if (empty)
                    ins_key = '0;
                else if (tail_key == KEY_MAX)
                    ins_key = KEY_MAX;
                else
                    ins_key = tail_key + KEY_W'(1);
            end
            default: ins_key = in_key;
        endcase
    end

    // command broadcast; a full list turns inserts into a hold
    always_comb
    begin
        ctrl.op   = CELL_HOLD;
        ctrl.key  = ins_key;
        ctrl.item = in_item;
        if (accept)
        begin
            case (in_action)
                ACT_PREPEND:    ctrl.op = full ? CELL_HOLD : CELL_INS_ALL;
                ACT_APPEND:     ctrl.op = full ? CELL_HOLD : CELL_INS_FREE;
                ACT_SORTED_INS: ctrl.op = full ? CELL_HOLD : CELL_INS_SORT;
                ACT_REMOVE_HD:  ctrl.op = CELL_DEL_HEAD;
                ACT_REMOVE_KEY: ctrl.op = CELL_DEL_KEY;
                default:        ctrl.op = CELL_HOLD;
            endcase
        end
    end

    assign hit_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            // first cell has no left neighbour, last cell sees an empty right neighbour
            if (g == 0)
            begin : g_left_edge
                assign left_entry[g] = '0;
            end
            else
            begin : g_left
                assign left_entry[g] = cell_entry[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_right_edge
                assign right_entry[g] = '0;
            end
            else
            begin : g_right
                assign right_entry[g] = cell_entry[g+1];
            end

            sklq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_entry  (left_entry[g]),
                .right_entry (right_entry[g]),
                .hit_in      (hit_chain[g]),
                .hit_out     (hit_chain[g+1]),
                .first_hit   (first_vec[g]),
                .entry       (cell_entry[g])
            );

            assign valid_vec[g] = cell_entry[g].valid;
        end
    endgenerate

    // removed entry is the first cell that matched
    always_comb
    begin
        rem_key  = '0;
        rem_item = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_vec[i])
            begin
                rem_key  = rem_key | cell_entry[i].key;
                rem_item = rem_item | cell_entry[i].item;
            end
        end
    end

    // status, result fields and next count
    always_comb
    begin
        status     = ST_OK;
        item_out   = '0;
        key_out    = '0;
        count_next = count_reg;
        case (in_action)
            ACT_PREPEND, ACT_APPEND, ACT_SORTED_INS:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    key_out    = ins_key;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_REMOVE_HD, ACT_REMOVE_KEY:
            begin
                if (hit_chain[CAPACITY])
                begin
                    item_out   = rem_item;
                    key_out    = rem_key;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                    status = ST_NOT_FOUND;
            end
            default: status = ST_OK;
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept)
        begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[STATUS_W-1:0]                    = status;
            m_data_next[STATUS_W +: ITEM_W]              = item_out;
            m_data_next[STATUS_W+ITEM_W +: KEY_W]        = key_out;
            m_data_next[STATUS_W+ITEM_W+KEY_W +: OCC_W]  = OCC_W'(count_next);
        end
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // occupied cells always match the count
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("occupied cells disagree with count");

    // occupied cells form a contiguous run from the head
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
        else $error("gap in occupied cells");

    // a rejected insert leaves the list untouched
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        accept && full && (in_action == ACT_PREPEND || in_action == ACT_APPEND
            || in_action == ACT_SORTED_INS) |=> $stable(count_reg) && $stable(valid_vec))
        else $error("insert into full list changed the list");

endmodule

// File: design/sklq_cell.sv
// sklq_cell: one list position, holding a single entry and shifting with its neighbours
// depends on sklq_pkg
module sklq_cell
    import sklq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    input  logic       hit_in,
    output logic       hit_out,
    output logic       first_hit,
    output entry_t     entry
);

    logic                    valid_reg, valid_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [ITEM_W-1:0]       item_reg, item_next;
    logic                    hit_here;
    logic                    is_ins;
    logic                    is_del;

    always_comb
    begin
        case (ctrl.op)
            CELL_INS_ALL:  hit_here = 1'b1;
            CELL_INS_FREE: hit_here = ~valid_reg;
            CELL_INS_SORT: hit_here = ~valid_reg | (key_reg >= ctrl.key);
            CELL_DEL_HEAD: hit_here = valid_reg;
            CELL_DEL_KEY:  hit_here = valid_reg & (key_reg == ctrl.key);
            default:       hit_here = 1'b0;
        endcase
    end

    assign is_ins    = (ctrl.op == CELL_INS_ALL) || (ctrl.op == CELL_INS_FREE)
                       || (ctrl.op == CELL_INS_SORT);
    assign is_del    = (ctrl.op == CELL_DEL_HEAD) || (ctrl.op == CELL_DEL_KEY);
    assign hit_out   = hit_in | hit_here;
    assign first_hit = hit_here & ~hit_in;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        item_next  = item_reg;
        if (is_ins)
        begin
            if (hit_in)
            begin
                valid_next = left_entry.valid;
                key_next   = left_entry.key;
                item_next  = left_entry.item;
            end
            else if (hit_here)
            begin
                valid_next = 1'b1;
                key_next   = ctrl.key;
                item_next  = ctrl.item;
            end
        end
        else if (is_del && hit_out)
        begin
            valid_next = right_entry.valid;
            key_next   = right_entry.key;
            item_next  = right_entry.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload needs no reset, an empty cell is never read
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        item_reg <= item_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.item  = item_reg;

endmodule

// File: verif/tb_sorted_key_list_queue.sv
// tb_sorted_key_list_queue: self-checking testbench for the sorted key list queue
// holds its own list predictor, directed and random traffic with idling on both sides
// depends on sklq_pkg and sorted_key_list_queue
`timescale 1ns / 100ps

module tb_sorted_key_list_queue;
    import sklq_pkg::*;

    // action codes the block treats as no operation
    localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

    localparam int IN_PAD_W       = IN_DATA_W - ACTION_W - ITEM_W - KEY_W;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 40;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic [ITEM_W-1:0]       item;
        logic signed [KEY_W-1:0] key;
        logic [OCC_W-1:0]        occ;
    } list_result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // predicted contents of the list, head at position 0
    logic signed [KEY_W-1:0] list_key [CAPACITY];
    logic [ITEM_W-1:0]       list_item[CAPACITY];
    int                      list_count = 0;

    list_result_t pending_results[$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    int           stall_left     = 0;
    bit           idle_on        = 1'b1;

    sorted_key_list_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // close the gap left by a removed entry
    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < list_count; i++)
        begin
            list_key[i]  = list_key[i + 1];
            list_item[i] = list_item[i + 1];
        end
        list_count--;
    endfunction

    // apply one transaction to the predicted list and return the result it gives
    function automatic list_result_t predict_list_op(input logic [ACTION_W-1:0]   act,
                                                     input logic [ITEM_W-1:0]     tag,
                                                     input logic signed [KEY_W-1:0] skey);
        list_result_t r;
        int           pos;
        int           i;
        bit           hit;
        logic signed [KEY_W-1:0] k;
        r.status = ST_OK;
        r.item   = '0;
        r.key    = '0;
        pos      = 0;
        hit      = 1'b0;
        k        = '0;
        if (act == ACT_PREPEND || act == ACT_APPEND || act == ACT_SORTED_INS)
        begin
            if (list_count >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                if (act == ACT_PREPEND)
                begin
                    // head key minus one, pinned at the lowest key
                    pos = 0;
                    if (list_count != 0)
                        k = (list_key[0] == KEY_MIN) ? KEY_MIN : list_key[0] - 1;
                end
                else if (act == ACT_APPEND)
                begin
                    pos = list_count;
                    if (list_count != 0)
                        k = (list_key[list_count - 1] == KEY_MAX) ? KEY_MAX
                                                                   : list_key[list_count - 1] + 1;
                end
                else
                begin
                    // before the first entry whose key is greater or equal
                    k   = skey;
                    pos = list_count;
                    for (i = 0; i < list_count; i++)
                        if (!hit && list_key[i] >= skey)
                        begin
                            pos = i;
                            hit = 1'b1;
                        end
                end
                for (i = list_count; i > pos; i--)
                begin
                    list_key[i]  = list_key[i - 1];
                    list_item[i] = list_item[i - 1];
                end
                list_key[pos]  = k;
                list_item[pos] = tag;
                list_count++;
                r.key = k;
            end
        end
        else if (act == ACT_REMOVE_HD)
        begin
            if (list_count == 0)
                r.status = ST_NOT_FOUND;
            else
            begin
                r.item = list_item[0];
                r.key  = list_key[0];
                drop_entry(0);
            end
        end
        else if (act == ACT_REMOVE_KEY)
        begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < list_count; i++)
                if (!hit && list_key[i] == skey)
                begin
                    pos = i;
                    hit = 1'b1;
                end
            if (hit)
            begin
                r.status = ST_OK;
                r.item   = list_item[pos];
                r.key    = list_key[pos];
                drop_entry(pos);
            end
        end
        r.occ = list_count[OCC_W-1:0];
        return r;
    endfunction

    // present one transaction, wait for the handshake, then record its prediction
    task automatic send_op(input logic [ACTION_W-1:0]   act,
                           input logic [ITEM_W-1:0]     tag,
                           input logic signed [KEY_W-1:0] skey);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_PAD_W{1'b0}}, skey, tag, act};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_list_op(act, tag, skey));
    endtask

    // key choice that favours collisions, extremes and keys already in the list
    function automatic logic signed [KEY_W-1:0] pick_key();
        int v;
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                v = $urandom_range(0, 16);
                k = v - 8;
            end
            3: k = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
            4: k = $urandom_range(0, 1) ? KEY_MIN + $urandom_range(0, 3)
                                        : KEY_MAX - $urandom_range(0, 3);
            5, 6: k = (list_count > 0) ? list_key[$urandom_range(0, list_count - 1)]
                                       : $urandom;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // one random transaction; insert_pct steers the list towards full or empty
    task automatic random_op(input int insert_pct);
        int roll;
        logic [ACTION_W-1:0] act;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            act = ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        else if (roll < 2 + insert_pct)
        begin
            case ($urandom_range(0, 2))
                0:       act = ACT_PREPEND;
                1:       act = ACT_APPEND;
                default: act = ACT_SORTED_INS;
            endcase
        end
        else
            act = ($urandom_range(0, 4) < 2) ? ACT_REMOVE_HD : ACT_REMOVE_KEY;
        send_op(act, $urandom, pick_key());
    endtask

    // empty list: removals miss, unused codes do nothing, inserts start at key zero
    task automatic test_empty_list();
        send_op(ACT_REMOVE_HD, $urandom, $urandom);
        send_op(ACT_REMOVE_KEY, $urandom, 0);
        send_op(ACT_UNUSED_FIRST, '1, KEY_MAX);
        send_op(ACTION_W'(ACT_UNUSED_FIRST + 1), '0, KEY_MIN);
        send_op(ACT_UNUSED_LAST, $urandom, $urandom);
        send_op(ACT_PREPEND, 32'h0000_0001, $urandom);
        send_op(ACT_REMOVE_HD, '0, '0);
        send_op(ACT_APPEND, 32'h8000_0000, $urandom);
        send_op(ACT_REMOVE_HD, '0, '0);
    endtask

    // key saturation at both ends, equal keys and first-match removal
    task automatic test_key_limits();
        send_op(ACT_SORTED_INS, '1, KEY_MIN);
        send_op(ACT_PREPEND, 32'h0000_00a1, $urandom);       // head stays at lowest key
        send_op(ACT_APPEND, 32'h0000_00a2, $urandom);        // tail is lowest, so plus one
        send_op(ACT_SORTED_INS, 32'h0000_00b1, KEY_MAX);
        send_op(ACT_APPEND, 32'h0000_00b2, $urandom);        // tail stays at highest key
        send_op(ACT_SORTED_INS, 32'h0000_00b3, KEY_MAX);     // lands before the equal keys
        send_op(ACT_SORTED_INS, 32'h5555_aaaa, 0);
        send_op(ACT_REMOVE_KEY, '0, KEY_MAX);                // takes the first match
        send_op(ACT_REMOVE_KEY, '0, 32'sd12345);             // not present
        send_op(ACT_REMOVE_KEY, '0, KEY_MIN);
        send_op(ACT_REMOVE_HD, '0, '0);
        send_op(ACT_REMOVE_HD, '0, '0);
        send_op(ACT_REMOVE_HD, '0, '0);
        send_op(ACT_REMOVE_HD, '0, '0);
        send_op(ACT_REMOVE_HD, '0, '0);
        send_op(ACT_REMOVE_HD, '0, '0);                      // already empty, so not found
    endtask

    // phases that fill, drain or mix, so the full and empty cases recur
    task automatic test_random_traffic(input int rounds);
        int bias;
        repeat (rounds)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0:       bias = 75;
                1:       bias = 25;
                default: bias = 50;
            endcase
            repeat (PHASE_ITEMS) random_op(bias);
        end
    endtask

    // back-to-back transactions with neither side idling
    task automatic test_steady_tail(input int count);
        idle_on = 1'b0;
        repeat (count) random_op(50);
    endtask

    // result side: random stall bursts and comparison with the oldest prediction
    always @(posedge clk)
    begin
        list_result_t want;
        list_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[STATUS_W-1:0];
            got.item   = m_tdata[STATUS_W +: ITEM_W];
            got.key    = m_tdata[STATUS_W + ITEM_W +: KEY_W];
            got.occ    = m_tdata[STATUS_W + ITEM_W + KEY_W +: OCC_W];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d item %h key %0d occupancy %0d",
                             got.status, got.item, got.key, got.occ);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.item !== want.item ||
                    got.key !== want.key || got.occ !== want.occ)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected status %0d item %h key %0d occupancy %0d",
                                 want.status, want.item, want.key, want.occ);
                        $display("          got      status %0d item %h key %0d occupancy %0d",
                                 got.status, got.item, got.key, got.occ);
                    end
                end
            end
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog on cycles where neither side completes a transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[sorted_key_list_queue] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_key_limits();
        test_random_traffic(30);
        test_steady_tail(250);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[sorted_key_list_queue] OK");
        else
            $display("[sorted_key_list_queue] ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/sklq_pkg.sv
design/sklq_cell.sv
design/sorted_key_list_queue.sv
verif/tb_sorted_key_list_queue.sv
